>>> rtl/cxa_pkg.sv
package cxa_pkg;

   localparam int ACTION_W  = 3;
   localparam int OPERAND_W = 32;
   localparam int STATUS_W  = 2;
   localparam int PROD_W    = 2 * OPERAND_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD = 3'd0,
      ACT_ADD  = 3'd1,
      ACT_SUB  = 3'd2,
      ACT_MUL  = 3'd3,
      ACT_DIV  = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK  = 2'd0,
      STAT_SAT = 2'd1,
      STAT_DZ  = 2'd2
   } status_type;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EXEC = 8'b0000_0010,
      S_MUL  = 8'b0000_0100,
      S_PART = 8'b0000_1000,
      S_CHK  = 8'b0001_0000,
      S_DIV  = 8'b0010_0000,
      S_FIN  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

endpackage

>>> rtl/cxa_req_if.sv
interface cxa_req_if import cxa_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [ACTION_W-1:0]         action;
   logic signed [OPERAND_W-1:0] operand_real;
   logic signed [OPERAND_W-1:0] operand_imag;

   modport source (output valid, action, operand_real, operand_imag, input ready);
   modport sink   (input valid, action, operand_real, operand_imag, output ready);
endinterface

>>> rtl/cxa_rsp_if.sv
interface cxa_rsp_if import cxa_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [OPERAND_W-1:0] result_real;
   logic signed [OPERAND_W-1:0] result_imag;
   logic [STATUS_W-1:0]         status;

   modport source (output valid, result_real, result_imag, status, input ready);
   modport sink   (input valid, result_real, result_imag, status, output ready);
endinterface

>>> rtl/complex_accumulator_alu.sv
// Channel   Direction  Contents
// req_ch    in         action, operand_real, operand_imag (signed fixed point)
// rsp_ch    out        result_real, result_imag, status
//
// Load, add, subtract, divide by zero and unused actions finish in S_EXEC and go to S_DONE.
// Multiply sends six products one at a time through the single 32x32
// multiplier. Divide also runs the one-bit-per-cycle restoring divider that
// serves both parts.
// Reset is synchronous and clears the accumulator, the sequencer and rsp valid.
// A waiting result does not block the next accept; a stalled rsp_ch holds the
// block in its final state until the previous item is taken.
module complex_accumulator_alu import cxa_pkg::*; #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic      clock,
   input logic      reset,
   cxa_req_if.sink  req_ch,
   cxa_rsp_if.source rsp_ch
);

   localparam int DW    = DATA_WIDTH;
   localparam int CNT_W = $clog2(DW);
   localparam int CW    = PROD_W + FRAC_BITS + DW;
   localparam logic signed [33:0] SUM_MAX = (34'sd1 <<< (DW - 1)) - 34'sd1;
   localparam logic signed [33:0] SUM_MIN = -(34'sd1 <<< (DW - 1));
   localparam logic [PROD_W-1:0]  LIM_NEG = PROD_W'(1) << (DW - 1);
   localparam logic [PROD_W-1:0]  LIM_POS = LIM_NEG - PROD_W'(1);
   localparam logic [2:0]         LAST_PROD = 3'd5;

   // Sequencer and item registers.
   state_type                    state_ff, state_in;
   logic [ACTION_W-1:0]          act_ff, act_in;
   logic signed [OPERAND_W-1:0]  br_ff, br_in, bi_ff, bi_in;
   logic signed [DW-1:0]         acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [DW-1:0]         res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic                         flag_ff, flag_in;
   logic                         dz_ff, dz_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         part_ff, part_in;

   // Shared multiplier, product registers and divider.
   logic signed [PROD_W-1:0]     p_ff [6];
   logic signed [OPERAND_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]     mul_out;
   logic [PROD_W-1:0]            mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic [PROD_W-1:0]            den_ff, den_in;
   logic [PROD_W-1:0]            rem_ff, rem_in;
   logic [DW-1:0]                nlo_ff, nlo_in;
   logic [DW-1:0]                q_ff, q_in;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [OPERAND_W-1:0]  rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic [STATUS_W-1:0]          rsp_st_ff, rsp_st_in;

   // Working signals.
   logic signed [PROD_W:0]       comb_sum;
   logic [CW-1:0]                num_wide;
   logic                         div_ovf;
   logic [PROD_W:0]              div_trial;
   logic [PROD_W-1:0]            fin_q;
   logic                         fin_ovf;
   logic [DW:0]                  fin_sat;
   logic signed [33:0]           lin_sum;
   logic [DW:0]                  lin_re, lin_im;
   logic                         req_fire;

   // Clamp a sign/magnitude value; returns {saturated, value}.
   function automatic logic [DW:0] sat_mag(input logic neg, input logic ovf,
                                            input logic [PROD_W-1:0] q);
      logic [PROD_W-1:0] qc;
      logic              f;
      f  = 1'b0;
      qc = q;
      if (neg) begin
         if (ovf || q > LIM_NEG) begin
            f  = 1'b1;
            qc = LIM_NEG;
         end
         return {f, DW'(PROD_W'(0) - qc)};
      end
      if (ovf || q > LIM_POS) begin
         f  = 1'b1;
         qc = LIM_POS;
      end
      return {f, DW'(qc)};
   endfunction

   // Clamp a signed sum; returns {saturated, value}.
   function automatic logic [DW:0] sat_val(input logic signed [33:0] v);
      if (v > SUM_MAX) begin
         return {1'b1, DW'(SUM_MAX)};
      end
      if (v < SUM_MIN) begin
         return {1'b1, DW'(SUM_MIN)};
      end
      return {1'b0, DW'(v)};
   endfunction

   assign req_fire      = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.result_real = rsp_re_ff;
   assign rsp_ch.result_imag = rsp_im_ff;
   assign rsp_ch.status = rsp_st_ff;

   // Product schedule: ar*br, ai*bi, ar*bi, ai*br, br*br, bi*bi.
   always_comb begin
      unique case (cnt_ff[2:0])
         3'd0:    begin mul_a = OPERAND_W'(acc_re_ff); mul_b = br_ff; end
         3'd1:    begin mul_a = OPERAND_W'(acc_im_ff); mul_b = bi_ff; end
         3'd2:    begin mul_a = OPERAND_W'(acc_re_ff); mul_b = bi_ff; end
         3'd3:    begin mul_a = OPERAND_W'(acc_im_ff); mul_b = br_ff; end
         3'd4:    begin mul_a = br_ff;                 mul_b = br_ff; end
         default: begin mul_a = bi_ff;                 mul_b = bi_ff; end
      endcase
   end
   assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Cross-term combination for the part in progress.
   always_comb begin
      if (act_ff == ACT_MUL) begin
         comb_sum = part_ff ? (65'(p_ff[2]) + 65'(p_ff[3]))
                            : (65'(p_ff[0]) - 65'(p_ff[1]));
      end else begin
         comb_sum = part_ff ? (65'(p_ff[3]) - 65'(p_ff[2]))
                            : (65'(p_ff[0]) + 65'(p_ff[1]));
      end
   end

   // The quotient fits in DW bits exactly when num * 2^F < den * 2^DW.
   assign num_wide  = CW'(mag_ff) << FRAC_BITS;
   assign div_ovf   = num_wide >= (CW'(den_ff) << DW);
   assign div_trial = {rem_ff, nlo_ff[DW-1]};

   always_comb begin
      fin_q   = '0;
      fin_ovf = 1'b0;
      if (state_ff == S_CHK) begin
         if (act_ff == ACT_MUL) begin
            fin_q = mag_ff >> FRAC_BITS;
         end else begin
            fin_ovf = div_ovf;
         end
      end else begin
         fin_q = PROD_W'(q_ff);
      end
   end
   assign fin_sat = sat_mag(neg_ff, fin_ovf, fin_q);

   always_comb begin
      lin_re = '0;
      lin_im = '0;
      lin_sum = '0;
      unique case (act_ff)
         ACT_LOAD: begin
            lin_re = sat_val(34'(br_ff));
            lin_im = sat_val(34'(bi_ff));
         end
         ACT_ADD: begin
            lin_sum = 34'(acc_re_ff) + 34'(br_ff);
            lin_re  = sat_val(lin_sum);
            lin_im  = sat_val(34'(acc_im_ff) + 34'(bi_ff));
         end
         ACT_SUB: begin
            lin_sum = 34'(acc_re_ff) - 34'(br_ff);
            lin_re  = sat_val(lin_sum);
            lin_im  = sat_val(34'(acc_im_ff) - 34'(bi_ff));
         end
         default: begin
            lin_re = {1'b0, acc_re_ff};
            lin_im = {1'b0, acc_im_ff};
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      br_in        = br_ff;
      bi_in        = bi_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      res_re_in    = res_re_ff;
      res_im_in    = res_im_ff;
      flag_in      = flag_ff;
      dz_in        = dz_ff;
      cnt_in       = cnt_ff;
      part_in      = part_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      nlo_in       = nlo_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_st_in    = rsp_st_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in   = req_ch.action;
               br_in    = req_ch.operand_real;
               bi_in    = req_ch.operand_imag;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            flag_in = 1'b0;
            dz_in   = 1'b0;
            cnt_in  = '0;
            part_in = 1'b0;
            if (act_ff == ACT_MUL) begin
               state_in = S_MUL;
            end else if (act_ff == ACT_DIV && br_ff != '0 || act_ff == ACT_DIV && bi_ff != '0) begin
               state_in = S_MUL;
            end else begin
               // Load, add, subtract, zero divisor and unused actions finish here.
               res_re_in = lin_re[DW-1:0];
               res_im_in = lin_im[DW-1:0];
               flag_in   = lin_re[DW] | lin_im[DW];
               dz_in     = (act_ff == ACT_DIV);
               state_in  = S_DONE;
            end
         end
         S_MUL: begin
            if (cnt_ff[2:0] == LAST_PROD) begin
               cnt_in   = '0;
               state_in = S_PART;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_PART: begin
            neg_in   = comb_sum[PROD_W];
            mag_in   = comb_sum[PROD_W] ? PROD_W'(-comb_sum) : PROD_W'(comb_sum);
            den_in   = PROD_W'(p_ff[4]) + PROD_W'(p_ff[5]);
            state_in = S_CHK;
         end
         S_CHK: begin
            if (act_ff == ACT_DIV && !div_ovf) begin
               rem_in   = PROD_W'(num_wide >> DW);
               nlo_in   = num_wide[DW-1:0];
               q_in     = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_trial >= {1'b0, den_ff}) begin
               rem_in = PROD_W'(div_trial - {1'b0, den_ff});
               q_in   = {q_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = PROD_W'(div_trial);
               q_in   = {q_ff[DW-2:0], 1'b0};
            end
            nlo_in = nlo_ff << 1;
            if (cnt_ff == CNT_W'(DW - 1)) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_FIN: begin
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               acc_re_in    = res_re_ff;
               acc_im_in    = res_im_ff;
               rsp_valid_in = 1'b1;
               rsp_re_in    = OPERAND_W'(res_re_ff);
               rsp_im_in    = OPERAND_W'(res_im_ff);
               if (dz_ff) begin
                  rsp_st_in = STAT_DZ;
               end else if (flag_ff) begin
                  rsp_st_in = STAT_SAT;
               end else begin
                  rsp_st_in = STAT_OK;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // A part finishes in S_CHK (multiply, or divide overflow) or in S_FIN.
      if ((state_ff == S_CHK && !(act_ff == ACT_DIV && !div_ovf)) || state_ff == S_FIN) begin
         if (part_ff) begin
            res_im_in = fin_sat[DW-1:0];
            state_in  = S_DONE;
         end else begin
            res_re_in = fin_sat[DW-1:0];
            part_in   = 1'b1;
            state_in  = S_PART;
         end
         flag_in = flag_ff | fin_sat[DW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         part_ff      <= 1'b0;
         flag_ff      <= 1'b0;
         dz_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_re_ff    <= acc_re_in;
         acc_im_ff    <= acc_im_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         part_ff      <= part_in;
         flag_ff      <= flag_in;
         dz_ff        <= dz_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      br_ff     <= br_in;
      bi_ff     <= bi_in;
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      nlo_ff    <= nlo_in;
      q_ff      <= q_in;
      rsp_re_ff <= rsp_re_in;
      rsp_im_ff <= rsp_im_in;
      rsp_st_ff <= rsp_st_in;
      if (state_ff == S_MUL) begin
         p_ff[cnt_ff[2:0]] <= mul_out;
      end
   end

endmodule

>>> sim/tb_top.sv
module tb_top;
   import cxa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int NUM_RANDOM = 1900;

   // One pending item for the driver.
   typedef struct {
      logic [ACTION_W-1:0]         action;
      logic signed [OPERAND_W-1:0] op_re;
      logic signed [OPERAND_W-1:0] op_im;
   } cx_item_type;

   typedef struct {
      logic signed [OPERAND_W-1:0] res_re;
      logic signed [OPERAND_W-1:0] res_im;
      logic [STATUS_W-1:0]         status;
   } cx_result_type;

   logic clock;
   logic reset;

   cxa_req_if req_ch ();
   cxa_rsp_if rsp_ch ();

   complex_accumulator_alu dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   cx_item_type   pending_items[$];
   cx_result_type expected_results[$];

   // Predicted accumulator, kept at 64 bits so the clamp can be seen.
   longint acc_re, acc_im;

   int  mismatches;
   int  items_sent, results_seen, mul_seen, div_seen, dz_seen, sat_seen;
   bit  stimulus_done;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Clamp a sign/magnitude value to the 32-bit signed range.
   function automatic longint clamp_mag(bit neg, logic [63:0] mag, ref bit sat);
      logic [63:0] lim_pos, lim_neg;
      lim_pos = 64'h7FFF_FFFF;
      lim_neg = 64'h8000_0000;
      if (neg) begin
         if (mag > lim_neg) begin
            sat = 1'b1;
            mag = lim_neg;
         end
         return -longint'(mag);
      end
      if (mag > lim_pos) begin
         sat = 1'b1;
         mag = lim_pos;
      end
      return longint'(mag);
   endfunction

   function automatic longint clamp_val(longint v, ref bit sat);
      if (v < 0) return clamp_mag(1'b1, 64'd0 - 64'(v), sat);
      return clamp_mag(1'b0, 64'(v), sat);
   endfunction

   // Exact p1 - p2 as sign and magnitude; both products fit well within 63 bits.
   function automatic logic [63:0] diff_mag(longint p1, longint p2, output bit neg);
      neg = p1 < p2;
      return neg ? 64'(p2) - 64'(p1) : 64'(p1) - 64'(p2);
   endfunction

   // Fixed-point quotient num * 2^FRAC / den, truncated and capped at 2^40.
   function automatic logic [63:0] fix_quot(logic [63:0] num, logic [63:0] den);
      logic [63:0] q, r, cap;
      cap = 64'd1 << 40;
      q = num / den;
      r = num % den;
      if (q > cap) q = cap;
      for (int i = 0; i < FRAC; i++) begin
         r = r << 1;
         if (r >= den) begin
            r = r - den;
            q = (q >= cap) ? cap : ((q << 1) | 64'd1);
         end else begin
            q = (q >= cap) ? cap : (q << 1);
         end
      end
      return q;
   endfunction

   // Apply one item to the predicted accumulator and queue the expected result.
   task automatic predict_accumulate(cx_item_type it);
      longint br, bi, nr, ni;
      bit sat, neg;
      logic [63:0] mag, den;
      cx_result_type r;
      br = longint'(it.op_re);
      bi = longint'(it.op_im);
      nr = acc_re;
      ni = acc_im;
      sat = 1'b0;
      r.status = STAT_OK;
      case (it.action)
         ACT_LOAD: begin
            nr = clamp_val(br, sat);
            ni = clamp_val(bi, sat);
         end
         ACT_ADD: begin
            nr = clamp_val(acc_re + br, sat);
            ni = clamp_val(acc_im + bi, sat);
         end
         ACT_SUB: begin
            nr = clamp_val(acc_re - br, sat);
            ni = clamp_val(acc_im - bi, sat);
         end
         ACT_MUL: begin
            mag = diff_mag(acc_re * br, acc_im * bi, neg);
            nr = clamp_mag(neg, mag >> FRAC, sat);
            mag = diff_mag(acc_re * bi, -(acc_im * br), neg);
            ni = clamp_mag(neg, mag >> FRAC, sat);
         end
         ACT_DIV: begin
            if (br == 0 && bi == 0) begin
               r.status = STAT_DZ;
            end else begin
               den = 64'(br * br) + 64'(bi * bi);
               mag = diff_mag(acc_re * br, -(acc_im * bi), neg);
               nr = clamp_mag(neg, fix_quot(mag, den), sat);
               mag = diff_mag(acc_im * br, acc_re * bi, neg);
               ni = clamp_mag(neg, fix_quot(mag, den), sat);
            end
         end
         default: ;
      endcase
      if (r.status == STAT_OK && sat) r.status = STAT_SAT;
      acc_re = nr;
      acc_im = ni;
      r.res_re = nr[31:0];
      r.res_im = ni[31:0];
      expected_results.push_back(r);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3: return 32'($signed($urandom_range(0, 16'hFFFF)) - 32768);
         4: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
         5: return 32'(int'($urandom_range(0, 8)) - 4) << FRAC;
         default: return $urandom;
      endcase
   endfunction

   function automatic cx_item_type make_item(logic [ACTION_W-1:0] a,
                                             logic [31:0] re, logic [31:0] im);
      cx_item_type it;
      it.action = a;
      it.op_re  = re;
      it.op_im  = im;
      return it;
   endfunction

   // Stimulus: a directed opening, then random items weighted toward the
   // arithmetic actions with a small share of the unused action codes.
   initial begin
      cx_item_type it;
      int unsigned sel;
      stimulus_done = 1'b0;
      // Directed: field extremes, each operation, saturation and divide by zero.
      pending_items.push_back(make_item(ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000));
      pending_items.push_back(make_item(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000));
      pending_items.push_back(make_item(ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF));
      pending_items.push_back(make_item(ACT_LOAD, 32'h0003_0000, 32'hFFFE_0000));
      pending_items.push_back(make_item(ACT_MUL, 32'h0001_8000, 32'h0002_0000));
      pending_items.push_back(make_item(ACT_DIV, 32'h0001_0000, 32'hFFFF_0000));
      pending_items.push_back(make_item(ACT_DIV, 32'd0, 32'd0));
      pending_items.push_back(make_item(ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_items.push_back(make_item(ACT_MUL, 32'h8000_0000, 32'h8000_0000));
      pending_items.push_back(make_item(ACT_DIV, 32'd1, 32'd0));
      pending_items.push_back(make_item(ACT_LOAD, 32'h8000_0000, 32'h8000_0000));
      pending_items.push_back(make_item(ACT_DIV, 32'h8000_0000, 32'h8000_0000));
      pending_items.push_back(make_item(ACT_DIV, 32'd0, 32'h7FFF_FFFF));
      pending_items.push_back(make_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(3'd6, 32'd0, 32'd0));
      pending_items.push_back(make_item(3'd7, 32'h1234_5678, 32'h8765_4321));
      pending_items.push_back(make_item(ACT_LOAD, 32'd0, 32'd0));
      pending_items.push_back(make_item(ACT_MUL, 32'hFFFF_FFFF, 32'h0000_0001));
      for (int n = 0; n < NUM_RANDOM; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 15)      it.action = ACT_LOAD;
         else if (sel < 32) it.action = ACT_ADD;
         else if (sel < 49) it.action = ACT_SUB;
         else if (sel < 72) it.action = ACT_MUL;
         else if (sel < 95) it.action = ACT_DIV;
         else               it.action = 3'($urandom_range(5, 7));
         it.op_re = rand_operand();
         it.op_im = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_operand();
         pending_items.push_back(it);
      end
      stimulus_done = 1'b1;
   end

   // Driver: pops an item, waits its drawn idle cycles, holds valid until accepted.
   int unsigned req_gap;
   bit          have_item;
   bit          burst_req;
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = '0;
      req_ch.operand_real = '0;
      req_ch.operand_imag = '0;
      rsp_ch.ready = 1'b0;
      acc_re = 0;
      acc_im = 0;
      mismatches = 0;
      items_sent = 0;
      results_seen = 0;
      mul_seen = 0;
      div_seen = 0;
      dz_seen = 0;
      sat_seen = 0;
      req_gap = 0;
      have_item = 1'b0;
      burst_req = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cx_item_type it;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            it = make_item(req_ch.action, req_ch.operand_real, req_ch.operand_imag);
            predict_accumulate(it);
            items_sent++;
            have_item = 1'b0;
         end
         // Occasionally switch into or out of a stretch without any idling.
         if ($urandom_range(0, 63) == 0) burst_req = ~burst_req;
         if (!have_item && pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_ch.action <= it.action;
            req_ch.operand_real <= it.op_re;
            req_ch.operand_imag <= it.op_im;
            req_gap = burst_req ? 0 : $urandom_range(0, 3);
            have_item = 1'b1;
         end
         if (have_item && req_gap == 0) begin
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end
      end
   end

   // Monitor: compares each accepted result with the oldest expectation and
   // throttles ready with a drawn stall per result.
   int unsigned rsp_stall;
   bit          burst_rsp;
   initial begin
      rsp_stall = 0;
      burst_rsp = 1'b0;
   end

   always @(posedge clock) begin
      cx_result_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result re=%h im=%h st=%0d",
                           rsp_ch.result_real, rsp_ch.result_imag, rsp_ch.status);
            end else begin
               want = expected_results.pop_front();
               if (want.status == STAT_SAT) sat_seen++;
               if (want.status == STAT_DZ) dz_seen++;
               if (rsp_ch.result_real !== want.res_re ||
                   rsp_ch.result_imag !== want.res_im ||
                   rsp_ch.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: result %0d expected re=%h im=%h st=%0d,",
                               " got re=%h im=%h st=%0d"},
                              results_seen, want.res_re, want.res_im, want.status,
                              rsp_ch.result_real, rsp_ch.result_imag, rsp_ch.status);
               end
            end
            rsp_stall = burst_rsp ? 0 : $urandom_range(0, 3);
         end
         if ($urandom_range(0, 63) == 0) burst_rsp = ~burst_rsp;
         if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Count the long operations as they are accepted, for the summary.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (req_ch.action == ACT_MUL) mul_seen++;
         if (req_ch.action == ACT_DIV) div_seen++;
      end
   end

   // End of run: all items accepted, every expected result back, then a drain.
   initial begin
      wait (stimulus_done);
      @(posedge clock);
      while (pending_items.size() > 0 || req_ch.valid || have_item ||
             expected_results.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Ran %0d items (%0d multiply, %0d divide); %0d results checked,",
               items_sent, mul_seen, div_seen, results_seen);
      $display("%0d saturated, %0d divide by zero, %0d mismatches.",
               sat_seen, dz_seen, mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: roughly 2000 items plus idling, many times over.
   initial begin
      #4ms;
      $display("ERROR: timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
